### sv/assert_macros.svh
// Assertion macros for the RTL of the tracker gate, used by its top-level file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under synchronous active-low reset.
`define CHK_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication under synchronous active-low reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/tatg_pkg.sv
// Package for the target acquire/track gate: widths, codes, types and angle tables.
`default_nettype none

package tatg_pkg;

  localparam int FRAME_WIDTH  = 640;
  localparam int FRAME_HEIGHT = 480;

  localparam int CX_W    = 10;
  localparam int CY_W    = 9;
  localparam int PAN_W   = 7;
  localparam int TILT_W  = 6;
  localparam int CNT_W   = 11;
  localparam int HOLD_W  = 13;
  localparam int ACQ_W   = 10;
  localparam int LIM_W   = 12;
  localparam int LOST_W  = 10;
  localparam int RAD_W   = 10;
  localparam int CFG_A_W = 3;
  localparam int CFG_D_W = 12;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 16;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;
  localparam logic [PAN_W-1:0] PAN_RESET = PAN_W'(30);
  localparam int PAN_MAX  = 80;
  localparam int TILT_MAX = 63;

  localparam logic FUNC_DET = 1'b0;
  localparam logic FUNC_EOF = 1'b1;

  typedef enum logic [CFG_A_W-1:0] {
    REG_AREA_LEFT,
    REG_AREA_TOP,
    REG_AREA_RIGHT,
    REG_AREA_BOTTOM,
    REG_ACQUIRE_FRAMES,
    REG_HOLD_LIMIT,
    REG_LOST_FRAMES,
    REG_MOVE_RADIUS
  } cfg_reg_t;

  typedef struct packed {
    logic            func;
    logic [CX_W-1:0] center_x;
    logic [CY_W-1:0] center_y;
  } item_t;

  typedef struct packed {
    logic              bulb_on;
    logic              is_tracking;
    logic [PAN_W-1:0]  pan_angle;
    logic [TILT_W-1:0] tilt_angle;
  } result_t;

  // Angle tables, built at elaboration from a fixed-point CORDIC.
  localparam int PAN_ROM_DEPTH  = 1 << CX_W;
  localparam int TILT_ROM_DEPTH = 1 << CY_W;
  typedef logic [PAN_W-1:0]  pan_rom_t  [PAN_ROM_DEPTH];
  typedef logic [TILT_W-1:0] tilt_rom_t [TILT_ROM_DEPTH];

  localparam int    CORDIC_STEPS   = 18;
  localparam longint TAN38_Q20     = 819237;
  localparam longint PAN_OFFSET_Q16 = 2577298;
  localparam longint ATAN_DEG_Q16 [CORDIC_STEPS] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335, 14668,
    7334, 3667, 1833, 917, 458, 229, 115, 57, 29
  };

  // Shift right, rounding toward zero like a signed divide.
  function automatic longint shr_trunc(longint v, int sh);
    longint mag;
    mag = (v < 0) ? -v : v;
    mag = mag >>> sh;
    return (v < 0) ? -mag : mag;
  endfunction

  function automatic longint offset_angle(longint d);
    longint x, y, z, xs, ys;
    x = longint'(FRAME_WIDTH / 2) <<< 20;
    y = d * TAN38_Q20;
    z = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = shr_trunc(x, i);
      ys = shr_trunc(y, i);
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_DEG_Q16[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_DEG_Q16[i];
      end
    end
    return z;
  endfunction

  function automatic longint clamp_deg(longint v, longint hi);
    longint w;
    w = v >>> 16;
    if (v < 0) return 0;
    if (w > hi) return hi;
    return w;
  endfunction

  function automatic pan_rom_t build_pan_rom();
    pan_rom_t r;
    longint   a;
    for (int i = 0; i < PAN_ROM_DEPTH; i++) begin
      a = offset_angle(longint'(i) - longint'(FRAME_WIDTH / 2));
      r[i] = PAN_W'(clamp_deg(PAN_OFFSET_Q16 - a, longint'(PAN_MAX)));
    end
    return r;
  endfunction

  function automatic tilt_rom_t build_tilt_rom();
    tilt_rom_t r;
    longint    half;
    longint    a;
    half = offset_angle(longint'(FRAME_HEIGHT / 2));
    for (int i = 0; i < TILT_ROM_DEPTH; i++) begin
      a = offset_angle(longint'(i) - longint'(FRAME_HEIGHT / 2));
      r[i] = TILT_W'(clamp_deg(a + half, longint'(TILT_MAX)));
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### sv/tatg_rom.sv
// Pan and tilt angle lookup ROMs with registered read data.
`default_nettype none

module tatg_rom
  import tatg_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rd_en,
  input  wire logic [CX_W-1:0]   center_x,
  input  wire logic [CY_W-1:0]   center_y,
  output logic      [PAN_W-1:0]  pan_q,
  output logic      [TILT_W-1:0] tilt_q
);

  localparam pan_rom_t  PAN_ROM  = build_pan_rom();
  localparam tilt_rom_t TILT_ROM = build_tilt_rom();

  logic [PAN_W-1:0]  pan_q_r;
  logic [TILT_W-1:0] tilt_q_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      pan_q_r  <= PAN_ROM[center_x];
      tilt_q_r <= TILT_ROM[center_y];
    end
  end

  assign pan_q  = pan_q_r;
  assign tilt_q = tilt_q_r;

endmodule

`default_nettype wire

### sv/tatg_ctrl.sv
// Acquire/track state, configuration registers and per-word update logic.
`default_nettype none

module tatg_ctrl
  import tatg_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [CFG_A_W-1:0] cfg_addr,
  input  wire logic [CFG_D_W-1:0] cfg_wdata,
  input  wire logic               adv,
  input  wire item_t              item,
  input  wire logic [PAN_W-1:0]   rom_pan,
  input  wire logic [TILT_W-1:0]  rom_tilt,
  output result_t                 res
);

  logic [CX_W-1:0]   area_left_r, area_right_r;
  logic [CY_W-1:0]   area_top_r, area_bottom_r;
  logic [ACQ_W-1:0]  acq_frames_r;
  logic [LIM_W-1:0]  hold_limit_r;
  logic [LOST_W-1:0] lost_frames_r;
  logic [RAD_W-1:0]  move_radius_r;

  logic              trk_r, trk_nxt;
  logic              lamp_r, lamp_nxt;
  logic              seen_r, seen_nxt;
  logic              fhd_r, fhd_nxt;
  logic [CNT_W-1:0]  acq_r, acq_nxt;
  logic [CNT_W-1:0]  efc_r, efc_nxt;
  logic [HOLD_W-1:0] hold_r, hold_nxt;
  logic [CX_W-1:0]   last_x_r, last_x_nxt;
  logic [CY_W-1:0]   last_y_r, last_y_nxt;
  logic [PAN_W-1:0]  pan_r, pan_nxt;
  logic [TILT_W-1:0] tilt_r, tilt_nxt;

  logic                    in_area;
  logic                    idle_hit;
  logic                    start;
  logic [CNT_W-1:0]        acq_inc;
  logic [CNT_W-1:0]        efc_inc;
  logic [CX_W-1:0]         ref_x;
  logic [CY_W-1:0]         ref_y;
  logic signed [CX_W:0]    dx;
  logic signed [CY_W:0]    dy;
  logic signed [2*CX_W+1:0] dx2;
  logic signed [2*CY_W+1:0] dy2;
  logic [2*CX_W+1:0]       dist2;
  logic [2*RAD_W-1:0]      rad2;
  logic                    near;
  logic                    upd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      area_left_r   <= '0;
      area_top_r    <= '0;
      area_right_r  <= '0;
      area_bottom_r <= '0;
      acq_frames_r  <= ACQ_W'(50);
      hold_limit_r  <= LIM_W'(700);
      lost_frames_r <= LOST_W'(100);
      move_radius_r <= RAD_W'(50);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_AREA_LEFT:      area_left_r   <= cfg_wdata[CX_W-1:0];
        REG_AREA_TOP:       area_top_r    <= cfg_wdata[CY_W-1:0];
        REG_AREA_RIGHT:     area_right_r  <= cfg_wdata[CX_W-1:0];
        REG_AREA_BOTTOM:    area_bottom_r <= cfg_wdata[CY_W-1:0];
        REG_ACQUIRE_FRAMES: acq_frames_r  <= cfg_wdata[ACQ_W-1:0];
        REG_HOLD_LIMIT:     hold_limit_r  <= cfg_wdata[LIM_W-1:0];
        REG_LOST_FRAMES:    lost_frames_r <= cfg_wdata[LOST_W-1:0];
        REG_MOVE_RADIUS:    move_radius_r <= cfg_wdata[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_area = (item.center_x > area_left_r) && (item.center_y > area_top_r) &&
                   (item.center_x < area_right_r) && (item.center_y < area_bottom_r);
  assign idle_hit = (item.func == FUNC_DET) && in_area && !trk_r;
  assign acq_inc  = (acq_r < COUNT_MAX) ? acq_r + CNT_W'(1) : acq_r;
  assign efc_inc  = (efc_r < COUNT_MAX) ? efc_r + CNT_W'(1) : efc_r;
  assign start    = idle_hit && (acq_inc > CNT_W'(acq_frames_r));

  // Compare against the position as it stands after a start on this word.
  assign ref_x = start ? item.center_x : last_x_r;
  assign ref_y = start ? item.center_y : last_y_r;
  assign dx    = $signed({1'b0, item.center_x}) - $signed({1'b0, ref_x});
  assign dy    = $signed({1'b0, item.center_y}) - $signed({1'b0, ref_y});
  assign dx2   = (2*CX_W+2)'(dx) * (2*CX_W+2)'(dx);
  assign dy2   = (2*CY_W+2)'(dy) * (2*CY_W+2)'(dy);
  assign dist2 = $unsigned(dx2 + (2*CX_W+2)'(dy2));
  assign rad2  = (2*RAD_W)'(move_radius_r) * (2*RAD_W)'(move_radius_r);
  assign near  = dist2 < (2*CX_W+2)'(rad2);

  always_comb begin
    trk_nxt    = trk_r;
    lamp_nxt   = lamp_r;
    seen_nxt   = seen_r;
    fhd_nxt    = fhd_r;
    acq_nxt    = acq_r;
    efc_nxt    = efc_r;
    hold_nxt   = hold_r;
    last_x_nxt = last_x_r;
    last_y_nxt = last_y_r;
    upd        = 1'b0;
    if (adv) begin
      if (item.func == FUNC_DET) begin
        efc_nxt = '0;
        fhd_nxt = 1'b1;
        if (idle_hit) begin
          seen_nxt = 1'b1;
          acq_nxt  = acq_inc;
          if (start) begin
            lamp_nxt   = 1'b1;
            trk_nxt    = 1'b1;
            last_x_nxt = item.center_x;
            last_y_nxt = item.center_y;
            upd        = 1'b1;
          end
        end else begin
          lamp_nxt = 1'b0;
        end
        if (trk_nxt) begin
          if (hold_r > HOLD_W'(hold_limit_r)) begin
            lamp_nxt = 1'b0;
            trk_nxt  = 1'b0;
            hold_nxt = '0;
          end else begin
            lamp_nxt = 1'b1;
            hold_nxt = hold_r + HOLD_W'(1);
            if (near) begin
              last_x_nxt = item.center_x;
              last_y_nxt = item.center_y;
              upd        = 1'b1;
            end
          end
        end
      end else begin
        if (!seen_r) acq_nxt = '0;
        seen_nxt = 1'b0;
        if (!fhd_r) begin
          efc_nxt = efc_inc;
          // Too many empty frames: drop the target
          if (efc_inc > CNT_W'(lost_frames_r)) begin
            lamp_nxt = 1'b0;
            trk_nxt  = 1'b0;
            acq_nxt  = '0;
            efc_nxt  = '0;
          end
        end
        fhd_nxt = 1'b0;
      end
    end
  end

  assign pan_nxt  = upd ? rom_pan : pan_r;
  assign tilt_nxt = upd ? rom_tilt : tilt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trk_r    <= 1'b0;
      lamp_r   <= 1'b0;
      seen_r   <= 1'b0;
      fhd_r    <= 1'b0;
      acq_r    <= '0;
      efc_r    <= '0;
      hold_r   <= '0;
      last_x_r <= '0;
      last_y_r <= '0;
      pan_r    <= PAN_RESET;
      tilt_r   <= '0;
    end else begin
      trk_r    <= trk_nxt;
      lamp_r   <= lamp_nxt;
      seen_r   <= seen_nxt;
      fhd_r    <= fhd_nxt;
      acq_r    <= acq_nxt;
      efc_r    <= efc_nxt;
      hold_r   <= hold_nxt;
      last_x_r <= last_x_nxt;
      last_y_r <= last_y_nxt;
      pan_r    <= pan_nxt;
      tilt_r   <= tilt_nxt;
    end
  end

  assign res.bulb_on     = lamp_nxt;
  assign res.is_tracking = trk_nxt;
  assign res.pan_angle   = pan_nxt;
  assign res.tilt_angle  = tilt_nxt;

endmodule

`default_nettype wire

### sv/target_acquire_track_gate.sv
// Top level of the target acquire/track gate: stream handshake, lookup, state, result register.
//
//  channel | dir | handshake          | payload
//  in_     | in  | in_tvalid/tready   | tuser: func; tdata: center_x, center_y
//  out_    | out | out_tvalid/tready  | tdata: bulb_on, is_tracking, pan, tilt
//  cfg_    | in  | cfg_we             | cfg_addr index, cfg_wdata value
//
// One word per cycle while the output is not stalled; the input word and its angle ROM
// read register together on acceptance, and the state update lands in the result
// register when the word advances, which raises out_tvalid.
// rst_n is synchronous; config and state return to their defaults on a clock edge while it is low.
// A stalled output holds its word; the stage behind it fills, then in_tready drops.
`default_nettype none

module target_acquire_track_gate
  import tatg_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // [9:0] center_x, [18:10] center_y
  input  wire logic                  in_tuser,   // [0] func
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic      [OUT_DATA_W-1:0] out_tdata,  // [0] bulb_on, [1] is_tracking,
                                                 // [8:2] pan_angle, [14:9] tilt_angle
  input  wire logic                  cfg_we,
  input  wire logic [CFG_A_W-1:0]    cfg_addr,
  input  wire logic [CFG_D_W-1:0]    cfg_wdata
);

`include "assert_macros.svh"

  logic              in_acc;
  logic              s1_adv;
  logic              s1_valid_r, s1_valid_nxt;
  item_t             s1_item_r;
  logic              out_valid_r, out_valid_nxt;
  result_t           out_res_r;
  result_t           res;
  logic [PAN_W-1:0]  rom_pan;
  logic [TILT_W-1:0] rom_tilt;

  assign s1_adv        = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready     = !s1_valid_r || s1_adv;
  assign in_acc        = in_tvalid && in_tready;
  assign s1_valid_nxt  = in_acc || (s1_valid_r && !s1_adv);
  assign out_valid_nxt = s1_adv || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r.func     <= in_tuser;
      s1_item_r.center_x <= in_tdata[CX_W-1:0];
      s1_item_r.center_y <= in_tdata[CX_W+CY_W-1:CX_W];
    end
    if (s1_adv) begin
      out_res_r <= res;
    end
  end

  tatg_rom u_rom (
    .clk      (clk),
    .rd_en    (in_acc),
    .center_x (in_tdata[CX_W-1:0]),
    .center_y (in_tdata[CX_W+CY_W-1:CX_W]),
    .pan_q    (rom_pan),
    .tilt_q   (rom_tilt)
  );

  tatg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .adv       (s1_adv),
    .item      (s1_item_r),
    .rom_pan   (rom_pan),
    .rom_tilt  (rom_tilt),
    .res       (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_res_r.tilt_angle, out_res_r.pan_angle,
                       out_res_r.is_tracking, out_res_r.bulb_on};

  `CHK_NOW(a_lamp_follows_track, clk, rst_n, out_valid_r,
    out_res_r.bulb_on == out_res_r.is_tracking, "lamp and tracking disagree")
  `CHK_NOW(a_pan_in_range, clk, rst_n, out_valid_r,
    out_res_r.pan_angle <= PAN_W'(PAN_MAX), "pan angle above limit")
  `CHK_NOW(a_full_pipe_stalls_input, clk, rst_n,
    s1_valid_r && out_valid_r && !out_tready, !in_tready, "input taken into full pipe")
  `CHK_NEXT(a_step_fills_output, clk, rst_n, s1_adv, out_valid_r,
    "advanced word missing at output")

endmodule

`default_nettype wire

### tb/target_acquire_track_gate_tb.sv
// Self-checking testbench for the target acquire/track gate: directed and random words, scoreboard.
`default_nettype none

module target_acquire_track_gate_tb
  import tatg_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_PRINTS = 30;
  localparam logic [CNT_W-1:0] COUNT_SAT = '1;

  // Fixed-point atan: tan(38 deg) in Q20, pan bias and per-step rotations in degrees Q16.
  localparam longint TAN38_FIX = 819237;
  localparam longint PAN_BIAS_Q16 = 2577298;
  localparam int ROT_STEPS = 18;
  localparam longint ROT_Q16 [ROT_STEPS] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335, 14668,
    7334, 3667, 1833, 917, 458, 229, 115, 57, 29
  };

  class gate_scoreboard;
    logic [CX_W-1:0]   area_left, area_right;
    logic [CY_W-1:0]   area_top, area_bottom;
    logic [ACQ_W-1:0]  acquire_frames;
    logic [LIM_W-1:0]  hold_limit;
    logic [LOST_W-1:0] lost_frames;
    logic [RAD_W-1:0]  move_radius;

    bit                tracking, lamp, seen_idle_hit, frame_hit;
    logic [CNT_W-1:0]  acq_cnt, empty_cnt;
    logic [HOLD_W-1:0] hold_cnt;
    logic [CX_W-1:0]   pos_x;
    logic [CY_W-1:0]   pos_y;
    logic [PAN_W-1:0]  pan;
    logic [TILT_W-1:0] tilt;

    result_t aim_q[$];
    int mismatches, n_det, n_eof, n_acq, n_expire, n_lost, n_aim;

    function new();
      area_left = '0; area_top = '0; area_right = '0; area_bottom = '0;
      acquire_frames = 50; hold_limit = 700; lost_frames = 100; move_radius = 50;
      tracking = 0; lamp = 0; seen_idle_hit = 0; frame_hit = 0;
      acq_cnt = '0; empty_cnt = '0; hold_cnt = '0;
      pos_x = '0; pos_y = '0; pan = PAN_W'(30); tilt = '0;
      mismatches = 0; n_det = 0; n_eof = 0; n_acq = 0; n_expire = 0; n_lost = 0; n_aim = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_D_W-1:0] v);
      case (idx)
        REG_AREA_LEFT:      area_left = v[CX_W-1:0];
        REG_AREA_TOP:       area_top = v[CY_W-1:0];
        REG_AREA_RIGHT:     area_right = v[CX_W-1:0];
        REG_AREA_BOTTOM:    area_bottom = v[CY_W-1:0];
        REG_ACQUIRE_FRAMES: acquire_frames = v[ACQ_W-1:0];
        REG_HOLD_LIMIT:     hold_limit = v[LIM_W-1:0];
        REG_LOST_FRAMES:    lost_frames = v[LOST_W-1:0];
        REG_MOVE_RADIUS:    move_radius = v[RAD_W-1:0];
        default: ;
      endcase
    endfunction

    // CORDIC vectoring of (half width, d * tan 38); divides truncate toward zero.
    function longint offset_atan_q16(longint d);
      longint x, y, z, xs, ys, dv;
      x = longint'(FRAME_WIDTH / 2) * 1048576;
      y = d * TAN38_FIX;
      z = 0;
      for (int i = 0; i < ROT_STEPS; i++) begin
        dv = longint'(1) << i;
        xs = x / dv;
        ys = y / dv;
        if (y >= 0) begin
          x = x + ys; y = y - xs; z = z + ROT_Q16[i];
        end else begin
          x = x - ys; y = y + xs; z = z - ROT_Q16[i];
        end
      end
      return z;
    endfunction

    function int whole_degrees(longint v, int hi);
      longint w;
      if (v < 0) return 0;
      w = v / 65536;
      if (w > hi) return hi;
      return int'(w);
    endfunction

    function void aim_at(logic [CX_W-1:0] cx, logic [CY_W-1:0] cy);
      pos_x = cx;
      pos_y = cy;
      pan = PAN_W'(whole_degrees(PAN_BIAS_Q16 -
                                 offset_atan_q16(longint'(cx) - FRAME_WIDTH / 2), PAN_MAX));
      tilt = TILT_W'(whole_degrees(offset_atan_q16(longint'(cy) - FRAME_HEIGHT / 2) +
                                   offset_atan_q16(FRAME_HEIGHT / 2), TILT_MAX));
      n_aim++;
    endfunction

    // Advance the gate state by one accepted word and queue the aim it produces.
    function void take_item(item_t it);
      result_t r;
      bit      in_area;
      longint  dx, dy, rad;
      if (it.func == FUNC_DET) begin
        n_det++;
        in_area = it.center_x > area_left && it.center_y > area_top &&
                  it.center_x < area_right && it.center_y < area_bottom;
        empty_cnt = '0;
        frame_hit = 1;
        if (in_area && !tracking) begin
          seen_idle_hit = 1;
          if (acq_cnt < COUNT_SAT) acq_cnt++;
          if (acq_cnt > acquire_frames) begin
            lamp = 1;
            tracking = 1;
            n_acq++;
            aim_at(it.center_x, it.center_y);
          end
        end else begin
          lamp = 0;
        end
        if (tracking) begin
          if (hold_cnt > hold_limit) begin
            lamp = 0;
            tracking = 0;
            hold_cnt = '0;
            n_expire++;
          end else begin
            dx = longint'(it.center_x) - longint'(pos_x);
            dy = longint'(it.center_y) - longint'(pos_y);
            rad = longint'(move_radius);
            lamp = 1;
            hold_cnt = hold_cnt + HOLD_W'(1);
            if (dx * dx + dy * dy < rad * rad) aim_at(it.center_x, it.center_y);
          end
        end
      end else begin
        n_eof++;
        if (!seen_idle_hit) acq_cnt = '0;
        seen_idle_hit = 0;
        if (!frame_hit) begin
          if (empty_cnt < COUNT_SAT) empty_cnt++;
          if (empty_cnt > lost_frames) begin
            lamp = 0;
            tracking = 0;
            acq_cnt = '0;
            empty_cnt = '0;
            n_lost++;
          end
        end
        frame_hit = 0;
      end
      r.bulb_on = lamp;
      r.is_tracking = tracking;
      r.pan_angle = pan;
      r.tilt_angle = tilt;
      aim_q.push_back(r);
    endfunction

    task report_mismatch(string what, int got, int want);
      if (mismatches < MAX_PRINTS)
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      mismatches++;
    endtask

    task check_aim(logic [OUT_DATA_W-1:0] word);
      result_t want;
      if (aim_q.size() == 0) begin
        report_mismatch("unexpected output word", int'(word), -1);
      end else begin
        want = aim_q.pop_front();
        if (word[0] !== want.bulb_on)
          report_mismatch("bulb_on", int'(word[0]), int'(want.bulb_on));
        if (word[1] !== want.is_tracking)
          report_mismatch("is_tracking", int'(word[1]), int'(want.is_tracking));
        if (word[8:2] !== want.pan_angle)
          report_mismatch("pan_angle", int'(word[8:2]), int'(want.pan_angle));
        if (word[14:9] !== want.tilt_angle)
          report_mismatch("tilt_angle", int'(word[14:9]), int'(want.tilt_angle));
      end
    endtask
  endclass

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // [9:0] center_x, [18:10] center_y
  logic                  in_tuser = 1'b0; // [0] func
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // [0] bulb_on, [1] is_tracking, [8:2] pan, [14:9] tilt
  logic                  cfg_we = 1'b0;
  logic [CFG_A_W-1:0]    cfg_addr = '0;
  logic [CFG_D_W-1:0]    cfg_wdata = '0;

  gate_scoreboard sb;
  bit tx_free = 0;
  bit rx_free = 0;
  int stall_left = 0;
  int quiet_cycles = 0;
  int n_words = 0;
  int n_settings = 0;

  target_acquire_track_gate DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Receiver: random back-pressure, mostly short stalls.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else if (!rx_free && $urandom_range(0, 99) < 20) begin
      out_tready <= 1'b0;
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 23) : $urandom_range(0, 2);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_aim(out_tdata);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int send_gap();
    int r;
    if (tx_free) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // Present one word and hold it until accepted; keep tvalid high across back-to-back words.
  task automatic send_item(logic f, logic [CX_W-1:0] cx, logic [CY_W-1:0] cy);
    item_t it;
    int    gap;
    gap = send_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= f;
    in_tdata <= IN_DATA_W'({cy, cx});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    it.func = f;
    it.center_x = cx;
    it.center_y = cy;
    sb.take_item(it);
    n_words++;
  endtask

  // Write all eight registers; optionally set the unused upper data bits at random.
  task automatic program_regs(logic [CFG_D_W-1:0] plan [8], bit junk);
    logic [CFG_D_W-1:0] v, hi_mask;
    int w;
    for (int i = 0; i < 8; i++) begin
      case (cfg_reg_t'(i))
        REG_AREA_TOP, REG_AREA_BOTTOM: w = CY_W;
        REG_HOLD_LIMIT:                w = LIM_W;
        default:                       w = CX_W;
      endcase
      hi_mask = ~((CFG_D_W'(1) << w) - CFG_D_W'(1));
      v = plan[i] | (junk ? (CFG_D_W'($urandom) & hi_mask) : '0);
      cfg_we <= 1'b1;
      cfg_addr <= cfg_reg_t'(i);
      cfg_wdata <= v;
      sb.write_reg(cfg_reg_t'(i), v);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
    n_settings++;
  endtask

  // Drop tvalid and drain every outstanding word before the next register change.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.aim_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Frames of detections around a drifting target, plus empty-frame runs and noise.
  task automatic run_traffic(int quota);
    int sent, kind, nd, pick, spread, tx, ty;
    sent = 0;
    tx = (int'(sb.area_left) + int'(sb.area_right)) / 2;
    ty = (int'(sb.area_top) + int'(sb.area_bottom)) / 2;
    spread = (sb.move_radius > 40) ? 40 : int'(sb.move_radius) + 3;
    while (sent < quota) begin
      kind = $urandom_range(0, 99);
      if (kind < 65) begin
        nd = $urandom_range(0, 3);
        for (int k = 0; k < nd; k++) begin
          pick = $urandom_range(0, 99);
          if (pick < 5) begin
            tx = $urandom_range(sb.area_left, sb.area_right);
            ty = $urandom_range(sb.area_top, sb.area_bottom);
          end
          if (pick < 75) begin
            tx = tx + int'($urandom_range(0, 2 * spread)) - spread;
            ty = ty + int'($urandom_range(0, 2 * spread)) - spread;
            tx = (tx < 0) ? 0 : ((tx > 1023) ? 1023 : tx);
            ty = (ty < 0) ? 0 : ((ty > 511) ? 511 : ty);
            send_item(FUNC_DET, CX_W'(tx), CY_W'(ty));
          end else if (pick < 88) begin
            send_item(FUNC_DET, CX_W'($urandom), CY_W'($urandom));
          end else begin
            send_item(FUNC_DET, CX_W'($urandom_range(sb.area_left, sb.area_right)),
                      CY_W'($urandom_range(sb.area_top, sb.area_bottom)));
          end
        end
        send_item(FUNC_EOF, CX_W'($urandom), CY_W'($urandom));
        sent += nd + 1;
      end else if (kind < 85) begin
        nd = $urandom_range(1, 5);
        for (int k = 0; k < nd; k++) send_item(FUNC_EOF, CX_W'($urandom), CY_W'($urandom));
        sent += nd;
      end else begin
        send_item(logic'($urandom), CX_W'($urandom), CY_W'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    logic [CFG_D_W-1:0] plan [8];
    int quota;
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: full area, fast acquire, short hold, widest radius.
    plan[REG_AREA_LEFT] = '0;
    plan[REG_AREA_TOP] = '0;
    plan[REG_AREA_RIGHT] = '1;
    plan[REG_AREA_BOTTOM] = '1;
    plan[REG_ACQUIRE_FRAMES] = 1;
    plan[REG_HOLD_LIMIT] = 8;
    plan[REG_LOST_FRAMES] = 1;
    plan[REG_MOVE_RADIUS] = 1023;
    program_regs(plan, 0);
    send_item(FUNC_EOF, 0, 0);
    send_item(FUNC_EOF, 1023, 511);
    send_item(FUNC_DET, 0, 0);
    send_item(FUNC_DET, 5, 5);
    send_item(FUNC_EOF, 0, 0);
    send_item(FUNC_DET, 6, 6);
    send_item(FUNC_DET, 0, 0);
    send_item(FUNC_DET, 1023, 511);
    send_item(FUNC_DET, 639, 479);
    send_item(FUNC_DET, 1022, 0);
    send_item(FUNC_DET, 0, 511);
    send_item(FUNC_DET, 320, 240);
    send_item(FUNC_DET, 1023, 0);
    send_item(FUNC_DET, 512, 256);
    send_item(FUNC_DET, 1, 1);
    send_item(FUNC_DET, 700, 300);
    send_item(FUNC_EOF, 1023, 511);
    send_item(FUNC_EOF, 0, 0);
    send_item(FUNC_EOF, 0, 0);
    send_item(FUNC_DET, 1022, 510);
    send_item(FUNC_DET, 1022, 510);
    send_item(FUNC_EOF, 0, 0);
    drain();

    for (int phase = 1; phase <= 6; phase++) begin
      tx_free = ($urandom_range(0, 3) == 0);
      rx_free = ($urandom_range(0, 3) == 0);
      plan[REG_AREA_LEFT] = $urandom_range(0, 200);
      plan[REG_AREA_TOP] = $urandom_range(0, 150);
      plan[REG_AREA_RIGHT] = $urandom_range(400, 700);
      plan[REG_AREA_BOTTOM] = $urandom_range(300, 511);
      quota = 110;
      case (phase)
        1: begin
          plan[REG_ACQUIRE_FRAMES] = $urandom_range(0, 3);
          plan[REG_HOLD_LIMIT] = $urandom_range(3, 30);
          plan[REG_LOST_FRAMES] = $urandom_range(0, 2);
          plan[REG_MOVE_RADIUS] = $urandom_range(5, 60);
        end
        2: begin
          // Everything at its floor, area as wide as the registers allow.
          plan[REG_AREA_LEFT] = '0;
          plan[REG_AREA_TOP] = '0;
          plan[REG_AREA_RIGHT] = '1;
          plan[REG_AREA_BOTTOM] = '1;
          plan[REG_ACQUIRE_FRAMES] = 0;
          plan[REG_HOLD_LIMIT] = 0;
          plan[REG_LOST_FRAMES] = 0;
          plan[REG_MOVE_RADIUS] = 0;
          quota = 90;
        end
        3: begin
          // Left, top and all limits at their ceiling, right and bottom at zero: empty area, no acquisition possible.
          plan[REG_AREA_LEFT] = '1;
          plan[REG_AREA_TOP] = '1;
          plan[REG_AREA_RIGHT] = '0;
          plan[REG_AREA_BOTTOM] = '0;
          plan[REG_ACQUIRE_FRAMES] = '1;
          plan[REG_HOLD_LIMIT] = '1;
          plan[REG_LOST_FRAMES] = '1;
          plan[REG_MOVE_RADIUS] = '1;
          quota = 50;
        end
        4: begin
          plan[REG_ACQUIRE_FRAMES] = $urandom_range(0, 6);
          plan[REG_HOLD_LIMIT] = $urandom_range(0, 60);
          plan[REG_LOST_FRAMES] = $urandom_range(0, 4);
          plan[REG_MOVE_RADIUS] = 1023;
        end
        5: begin
          plan[REG_ACQUIRE_FRAMES] = $urandom_range(0, 2);
          plan[REG_HOLD_LIMIT] = '1;
          plan[REG_LOST_FRAMES] = $urandom_range(1, 3);
          plan[REG_MOVE_RADIUS] = $urandom_range(20, 200);
          quota = 100;
        end
        default: begin
          plan[REG_AREA_LEFT] = $urandom_range(0, 320);
          plan[REG_AREA_TOP] = $urandom_range(0, 240);
          plan[REG_AREA_RIGHT] = $urandom_range(320, 1023);
          plan[REG_AREA_BOTTOM] = $urandom_range(240, 511);
          plan[REG_ACQUIRE_FRAMES] = $urandom_range(1, 4);
          plan[REG_HOLD_LIMIT] = $urandom_range(5, 100);
          plan[REG_LOST_FRAMES] = $urandom_range(0, 3);
          plan[REG_MOVE_RADIUS] = $urandom_range(30, 120);
        end
      endcase
      program_regs(plan, phase != 2 && phase != 3);
      run_traffic(quota);
      drain();
    end

    repeat (10) @(posedge clk);
    if (sb.aim_q.size() != 0) sb.report_mismatch("words never produced", 0, sb.aim_q.size());
    $display("Ran %0d words (%0d detections, %0d frame ends) under %0d register settings.",
             n_words, sb.n_det, sb.n_eof, n_settings);
    $display("Saw %0d acquisitions, %0d hold expiries, %0d lost targets, %0d aim updates.",
             sb.n_acq, sb.n_expire, sb.n_lost, sb.n_aim);
    if (sb.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
